FILE: hw/rtl/bilinear_rgb_resize_macros.svh
// ----------------------------------------------------------------------------
// Bilinear RGB resize: assertion macros
// Short forms for the concurrent checks used across the block.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_RGB_RESIZE_MACROS_SVH
`define BILINEAR_RGB_RESIZE_MACROS_SVH

// Same-cycle implication, muted while reset is asserted.
`define BRR_ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, muted while reset is asserted.
`define BRR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/brr_pkg.sv
// ----------------------------------------------------------------------------
// Bilinear RGB resize: shared package
// Field widths, register indexes, operation codes and common types.
// ----------------------------------------------------------------------------
package brr_pkg;

  localparam int unsigned SIZE_W  = 9;   // src_width / src_height registers
  localparam int unsigned STEP_W  = 25;  // x_step / y_step, unsigned Q16
  localparam int unsigned COORD_W = 16;  // destination coordinates
  localparam int unsigned FRAC_W  = 16;  // Q16 weights
  localparam int unsigned CH_W    = 8;
  localparam int unsigned PIX_W   = 3 * CH_W;

  // (2d+1)*step in Q17, its Q16 half and the integer part of that
  localparam int unsigned Q17_W = COORD_W + 1 + STEP_W;
  localparam int unsigned Q16_W = Q17_W - 1;
  localparam int unsigned IP_W  = Q16_W - FRAC_W;

  localparam int unsigned HB_W = CH_W + FRAC_W;          // horizontal blend, Q16
  localparam int unsigned VB_W = HB_W + FRAC_W + 1;      // vertical blend, Q32

  localparam logic [Q17_W-1:0] HALF_PIXEL_Q17 = Q17_W'(1) << FRAC_W;
  localparam logic [FRAC_W:0]  WEIGHT_ONE     = (FRAC_W + 1)'(1) << FRAC_W;
  localparam logic [VB_W-1:0]  ROUND_HALF     = VB_W'(1) << (2 * FRAC_W - 1);
  localparam logic [CH_W:0]    CH_MAX         = (CH_W + 1)'(255);

  localparam int unsigned CMD_DEPTH  = 2;
  localparam int unsigned OUT_DEPTH  = 4;
  localparam int unsigned OUT_CNT_W  = $clog2(OUT_DEPTH + 1);
  localparam int unsigned REG_IDX_W  = 2;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } brr_op_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_X_STEP     = 2'd2,
    REG_Y_STEP     = 2'd3
  } brr_reg_e;

  typedef struct packed {
    logic [SIZE_W-1:0] src_width;
    logic [SIZE_W-1:0] src_height;
    logic [STEP_W-1:0] x_step;
    logic [STEP_W-1:0] y_step;
  } brr_cfg_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } brr_pix_t;

endpackage

FILE: hw/rtl/brr_ram.sv
// ----------------------------------------------------------------------------
// Bilinear RGB resize: generic RAM
// One write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module brr_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 65536,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

FILE: hw/rtl/brr_fifo.sv
// ----------------------------------------------------------------------------
// Bilinear RGB resize: small FIFO
// Register-based queue with occupancy count, first-word fall-through.
// ----------------------------------------------------------------------------
module brr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o,
  output logic [CW-1:0]    count_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d;
  logic [PW-1:0]    rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

FILE: hw/rtl/brr_front.sv
// ----------------------------------------------------------------------------
// Bilinear RGB resize: front end
// Takes transactions, keeps the load pointer, maps query coordinates to
// neighbour indices and weights, and forms the four store addresses.
// ----------------------------------------------------------------------------
module brr_front #(
  parameter int unsigned MAX_SRC_WIDTH  = 256,
  parameter int unsigned MAX_SRC_HEIGHT = 256,
  localparam int unsigned AW = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  brr_pkg::brr_cfg_t             cfg_i,
  input  logic                          cfg_wr_i,
  input  logic                          push_i,
  output logic                          full_o,
  input  brr_pkg::brr_op_e              op_i,
  input  brr_pkg::brr_pix_t             pix_i,
  input  logic [brr_pkg::COORD_W-1:0]   out_x_i,
  input  logic [brr_pkg::COORD_W-1:0]   out_y_i,
  output logic                          cmd_valid_o,
  input  logic                          cmd_ready_i,
  output brr_pkg::brr_op_e              cmd_op_o,
  output brr_pkg::brr_pix_t             cmd_pix_o,
  output logic [3:0][AW-1:0]            cmd_addr_o,
  output logic [brr_pkg::FRAC_W-1:0]    cmd_wx_o,
  output logic [brr_pkg::FRAC_W-1:0]    cmd_wy_o
);
  import brr_pkg::*;

  localparam int unsigned DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int unsigned TW    = $clog2(DEPTH + 1);
  localparam int unsigned XW    = $clog2(MAX_SRC_WIDTH);
  localparam int unsigned YW    = $clog2(MAX_SRC_HEIGHT);
  localparam int unsigned IW    = (XW > YW) ? XW : YW;
  localparam int unsigned WSW   = $clog2(MAX_SRC_WIDTH + 1);
  localparam int unsigned HSW   = $clog2(MAX_SRC_HEIGHT + 1);
  localparam int unsigned SW    = (WSW > HSW) ? WSW : HSW;

  logic           en, accept, settle_q;
  logic [WSW-1:0] w_eff;
  logic [HSW-1:0] h_eff;
  logic [SW-1:0]  lim [2];
  logic [TW-1:0]  total_q, wptr_inc;
  logic [AW-1:0]  wptr_q, wptr_d;

  // stage 1: captured transaction
  logic               s1_valid_q;
  brr_op_e            s1_op_q;
  brr_pix_t           s1_pix_q;
  logic [AW-1:0]      s1_addr_q;
  logic [COORD_W-1:0] s1_d_q [2];

  // stage 2: Q17 source coordinates
  logic               s2_valid_q;
  brr_op_e            s2_op_q;
  brr_pix_t           s2_pix_q;
  logic [AW-1:0]      s2_addr_q;
  logic [Q17_W-1:0]   q17_d [2];
  logic [Q17_W-1:0]   s2_q17_q [2];

  // stage 3: neighbour indices and weights
  logic               s3_valid_q;
  brr_op_e            s3_op_q;
  brr_pix_t           s3_pix_q;
  logic [AW-1:0]      s3_addr_q;
  logic [Q16_W-1:0]   q16 [2];
  logic [IP_W-1:0]    ip [2];
  logic [IW-1:0]      i0_d [2];
  logic [IW-1:0]      i1_d [2];
  logic [FRAC_W-1:0]  w_d [2];
  logic [IW-1:0]      s3_i0_q [2];
  logic [IW-1:0]      s3_i1_q [2];
  logic [FRAC_W-1:0]  s3_w_q [2];

  logic [AW-1:0] row0, row1;

  // whole pipe moves together; it stops only when the last stage cannot drain
  assign en     = !s3_valid_q || cmd_ready_i;
  assign full_o = !en || settle_q;
  assign accept = push_i && !full_o;

  // sizes out of range: zero acts as one, above the maximum acts as the maximum
  always_comb begin
    if (cfg_i.src_width == '0) begin
      w_eff = WSW'(1);
    end else if (32'(cfg_i.src_width) > 32'(MAX_SRC_WIDTH)) begin
      w_eff = WSW'(MAX_SRC_WIDTH);
    end else begin
      w_eff = WSW'(cfg_i.src_width);
    end
    if (cfg_i.src_height == '0) begin
      h_eff = HSW'(1);
    end else if (32'(cfg_i.src_height) > 32'(MAX_SRC_HEIGHT)) begin
      h_eff = HSW'(MAX_SRC_HEIGHT);
    end else begin
      h_eff = HSW'(cfg_i.src_height);
    end
    lim[0] = SW'(w_eff) - SW'(1);
    lim[1] = SW'(h_eff) - SW'(1);
  end

  // load pointer wraps at width*height, also when already past a shrunk size
  assign wptr_inc = TW'(wptr_q) + TW'(1);
  assign wptr_d   = (wptr_inc >= total_q) ? '0 : AW'(wptr_inc);

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      q17_d[a] = {s1_d_q[a], 1'b1} * ((a == 0) ? cfg_i.x_step : cfg_i.y_step);
    end
  end

  // half-pixel centre, clamp at zero, floor to Q16, clamp to last index
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      if (s2_q17_q[a] > HALF_PIXEL_Q17) begin
        q16[a] = Q16_W'((s2_q17_q[a] - HALF_PIXEL_Q17) >> 1);
      end else begin
        q16[a] = '0;
      end
      ip[a] = q16[a][Q16_W-1:FRAC_W];
      if (ip[a] >= IP_W'(lim[a])) begin
        i0_d[a] = IW'(lim[a]);
        i1_d[a] = IW'(lim[a]);
        w_d[a]  = '0;
      end else begin
        i0_d[a] = IW'(ip[a]);
        i1_d[a] = IW'(ip[a]) + IW'(1);
        w_d[a]  = q16[a][FRAC_W-1:0];
      end
    end
  end

  assign row0 = AW'(s3_i0_q[1]) * AW'(w_eff);
  assign row1 = AW'(s3_i1_q[1]) * AW'(w_eff);

  assign cmd_valid_o = s3_valid_q;
  assign cmd_op_o    = s3_op_q;
  assign cmd_pix_o   = s3_pix_q;
  assign cmd_wx_o    = s3_w_q[0];
  assign cmd_wy_o    = s3_w_q[1];

  always_comb begin
    if (s3_op_q == OP_LOAD) begin
      cmd_addr_o = {4{s3_addr_q}};
    end else begin
      cmd_addr_o[0] = row0 + AW'(s3_i0_q[0]);
      cmd_addr_o[1] = row0 + AW'(s3_i1_q[0]);
      cmd_addr_o[2] = row1 + AW'(s3_i0_q[0]);
      cmd_addr_o[3] = row1 + AW'(s3_i1_q[0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q   <= 1'b1;
      wptr_q     <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      settle_q <= cfg_wr_i;
      if (accept && op_i == OP_LOAD) begin
        wptr_q <= wptr_d;
      end
      if (en) begin
        s1_valid_q <= accept;
        s2_valid_q <= s1_valid_q;
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    total_q <= TW'(w_eff) * TW'(h_eff);
    if (en) begin
      s1_op_q   <= op_i;
      s1_pix_q  <= pix_i;
      s1_addr_q <= wptr_q;
      s1_d_q[0] <= out_x_i;
      s1_d_q[1] <= out_y_i;
      s2_op_q   <= s1_op_q;
      s2_pix_q  <= s1_pix_q;
      s2_addr_q <= s1_addr_q;
      s2_q17_q  <= q17_d;
      s3_op_q   <= s2_op_q;
      s3_pix_q  <= s2_pix_q;
      s3_addr_q <= s2_addr_q;
      s3_i0_q   <= i0_d;
      s3_i1_q   <= i1_d;
      s3_w_q    <= w_d;
    end
  end

endmodule

FILE: hw/rtl/brr_back.sv
// ----------------------------------------------------------------------------
// Bilinear RGB resize: back end
// Runs commands against the frame store: a load is one write, a query is two
// double reads followed by the horizontal and vertical blends.
// ----------------------------------------------------------------------------
`include "bilinear_rgb_resize_macros.svh"

module brr_back #(
  parameter int unsigned MAX_SRC_WIDTH  = 256,
  parameter int unsigned MAX_SRC_HEIGHT = 256,
  localparam int unsigned AW = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_pop_o,
  input  brr_pkg::brr_op_e              cmd_op_i,
  input  brr_pkg::brr_pix_t             cmd_pix_i,
  input  logic [3:0][AW-1:0]            cmd_addr_i,
  input  logic [brr_pkg::FRAC_W-1:0]    cmd_wx_i,
  input  logic [brr_pkg::FRAC_W-1:0]    cmd_wy_i,
  output logic                          res_valid_o,
  output brr_pkg::brr_pix_t             res_pix_o,
  input  logic [brr_pkg::OUT_CNT_W-1:0] out_count_i
);
  import brr_pkg::*;

  localparam int unsigned DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;

  logic          phase_q;
  logic          iss0, iss1, room;
  logic          ram_we;
  logic [AW-1:0] raddr_a, raddr_b;
  logic [PIX_W-1:0] rdata_a, rdata_b;
  logic [OUT_CNT_W-1:0] inflight_q;
  logic [OUT_CNT_W:0]   credit_used;

  logic              rd_valid_q, rd_phase_q;
  logic [FRAC_W-1:0] rd_wx_q, rd_wy_q;

  logic [2:0][CH_W-1:0] ch_a, ch_b;
  logic [FRAC_W:0]      hinv;
  logic [HB_W:0]        hsum [3];
  logic [HB_W-1:0]      top_q [3];

  logic              v_valid_q;
  logic [HB_W-1:0]   vtop_q [3];
  logic [HB_W-1:0]   vbot_q [3];
  logic [FRAC_W-1:0] vwy_q;
  logic [FRAC_W:0]   vinv;
  logic [VB_W-1:0]   vsum [3];
  logic [CH_W:0]     vr [3];
  logic [2:0][CH_W-1:0] res_ch;

  // a query only starts when its result is sure to find room
  assign credit_used = (OUT_CNT_W + 1)'(inflight_q) + (OUT_CNT_W + 1)'(out_count_i);
  assign room        = credit_used < (OUT_CNT_W + 1)'(OUT_DEPTH);

  always_comb begin
    ram_we    = 1'b0;
    cmd_pop_o = 1'b0;
    iss0      = 1'b0;
    iss1      = 1'b0;
    raddr_a   = cmd_addr_i[0];
    raddr_b   = cmd_addr_i[1];
    if (phase_q) begin
      raddr_a   = cmd_addr_i[2];
      raddr_b   = cmd_addr_i[3];
      iss1      = 1'b1;
      cmd_pop_o = 1'b1;
    end else if (cmd_valid_i) begin
      if (cmd_op_i == OP_LOAD) begin
        ram_we    = 1'b1;
        cmd_pop_o = 1'b1;
      end else if (room) begin
        iss0 = 1'b1;
      end
    end
  end

  brr_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (cmd_addr_i[0]),
    .wdata_i   (cmd_pix_i),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // horizontal blend, exact in Q16
  assign ch_a = rdata_a;
  assign ch_b = rdata_b;
  assign hinv = WEIGHT_ONE - (FRAC_W + 1)'(rd_wx_q);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      hsum[c] = ch_a[c] * hinv + ch_b[c] * {1'b0, rd_wx_q};
    end
  end

  // vertical blend in Q32, round half up, saturate
  assign vinv = WEIGHT_ONE - (FRAC_W + 1)'(vwy_q);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      vsum[c] = vtop_q[c] * vinv + vbot_q[c] * {1'b0, vwy_q} + ROUND_HALF;
      vr[c]   = vsum[c][VB_W-1:2*FRAC_W];
      res_ch[c] = (vr[c] > CH_MAX) ? CH_MAX[CH_W-1:0] : vr[c][CH_W-1:0];
    end
  end

  assign res_valid_o = v_valid_q;
  assign res_pix_o   = res_ch;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= 1'b0;
      inflight_q <= '0;
      rd_valid_q <= 1'b0;
      v_valid_q  <= 1'b0;
    end else begin
      phase_q    <= iss0;
      rd_valid_q <= iss0 || iss1;
      v_valid_q  <= rd_valid_q && rd_phase_q;
      if (iss0 && !v_valid_q) begin
        inflight_q <= inflight_q + OUT_CNT_W'(1);
      end else if (v_valid_q && !iss0) begin
        inflight_q <= inflight_q - OUT_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_phase_q <= iss1;
    rd_wx_q    <= cmd_wx_i;
    rd_wy_q    <= cmd_wy_i;
    if (rd_valid_q && !rd_phase_q) begin
      for (int c = 0; c < 3; c++) begin
        top_q[c] <= hsum[c][HB_W-1:0];
      end
    end
    if (rd_valid_q && rd_phase_q) begin
      vwy_q <= rd_wy_q;
      for (int c = 0; c < 3; c++) begin
        vtop_q[c] <= top_q[c];
        vbot_q[c] <= hsum[c][HB_W-1:0];
      end
    end
  end

  `BRR_ASSERT_NEXT(a_second_read, clk_i, rst_ni, iss0, iss1 && cmd_pop_o, "query lost its second read")
  `BRR_ASSERT_IMPLIES(a_out_room, clk_i, rst_ni, res_valid_o, out_count_i < OUT_CNT_W'(OUT_DEPTH), "result queue overrun")
  `BRR_ASSERT_IMPLIES(a_credit, clk_i, rst_ni, 1'b1, credit_used <= (OUT_CNT_W + 1)'(OUT_DEPTH), "result credit exceeded")
  `BRR_ASSERT_IMPLIES(a_no_write_mid_query, clk_i, rst_ni, phase_q, !ram_we, "store write inside a query")

endmodule

FILE: hw/rtl/bilinear_rgb_resize.sv
// ----------------------------------------------------------------------------
// Bilinear RGB resize (half-pixel centres)
// RGB888 frame store loaded in raster order; each query returns one bilinearly
// interpolated pixel, rounded to 8 bits per channel from a Q32 blend.
// ----------------------------------------------------------------------------
//  Channel   Handshake               Moves
//  --------  ----------------------  -----------------------------------------
//  input     push / full             operation, red, green, blue, out_x, out_y
//  result    empty / pop             out_red, out_green, out_blue
//  config    cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
//  A load occupies the back end with one store write; a query with two reads,
//  since its four neighbours come through the store's two read ports.
//  With idle queues, an accepted query passes two more front stages, the
//  command queue, two reads, blend register, result queue, then empty falls.
//  Reset clears the load pointer and queues; the frame store is not cleared.
//  full rises for one cycle after reset and after every config write.
//  A stalled result queue holds a query at the head of the command queue and
//  everything behind it waits; full rises once the last front stage is blocked.
// ----------------------------------------------------------------------------
module bilinear_rgb_resize #(
  parameter int unsigned MAX_SRC_WIDTH  = 256,
  parameter int unsigned MAX_SRC_HEIGHT = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input queue
  input  logic                             push,
  output logic                             full,
  input  logic                             operation_i,
  input  logic [brr_pkg::CH_W-1:0]         red_i,
  input  logic [brr_pkg::CH_W-1:0]         green_i,
  input  logic [brr_pkg::CH_W-1:0]         blue_i,
  input  logic [brr_pkg::COORD_W-1:0]      out_x_i,
  input  logic [brr_pkg::COORD_W-1:0]      out_y_i,
  // result queue
  output logic                             empty,
  input  logic                             pop,
  output logic [brr_pkg::CH_W-1:0]         out_red_o,
  output logic [brr_pkg::CH_W-1:0]         out_green_o,
  output logic [brr_pkg::CH_W-1:0]         out_blue_o,
  // register writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [brr_pkg::REG_IDX_W-1:0]    cfg_index_i,
  input  logic [brr_pkg::STEP_W-1:0]       cfg_data_i
);
  import brr_pkg::*;

  localparam int unsigned AW = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT);

  // command handed from front to back through a short queue
  typedef struct packed {
    brr_op_e            op;
    brr_pix_t           pix;
    logic [3:0][AW-1:0] addr;
    logic [FRAC_W-1:0]  wx;
    logic [FRAC_W-1:0]  wy;
  } cmd_t;

  brr_cfg_t cfg_q;
  logic     cfg_wr;

  cmd_t front_cmd, back_cmd;
  logic front_valid, cmdq_full, cmdq_empty, back_pop;
  logic [$clog2(CMD_DEPTH + 1)-1:0] cmdq_count;

  logic     res_valid;
  brr_pix_t res_pix, out_pix;
  logic     outq_full;
  logic [OUT_CNT_W-1:0] outq_count;

  brr_pix_t in_pix;

  // -------------------------------------------------------------------------
  // Register file. Always ready; writes land at once, the front end then
  // holds off new transactions while derived sizes settle.
  // -------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_width  <= SIZE_W'(256);
      cfg_q.src_height <= SIZE_W'(256);
      cfg_q.x_step     <= STEP_W'(65536);
      cfg_q.y_step     <= STEP_W'(65536);
    end else if (cfg_wr) begin
      case (brr_reg_e'(cfg_index_i))
        REG_SRC_WIDTH:  cfg_q.src_width  <= cfg_data_i[SIZE_W-1:0];
        REG_SRC_HEIGHT: cfg_q.src_height <= cfg_data_i[SIZE_W-1:0];
        REG_X_STEP:     cfg_q.x_step     <= cfg_data_i;
        REG_Y_STEP:     cfg_q.y_step     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Front end: takes transactions, maps coordinates, forms store addresses.
  // -------------------------------------------------------------------------
  assign in_pix = '{red: red_i, green: green_i, blue: blue_i};

  brr_front #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cfg_wr_i    (cfg_wr),
    .push_i      (push),
    .full_o      (full),
    .op_i        (brr_op_e'(operation_i)),
    .pix_i       (in_pix),
    .out_x_i     (out_x_i),
    .out_y_i     (out_y_i),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (!cmdq_full),
    .cmd_op_o    (front_cmd.op),
    .cmd_pix_o   (front_cmd.pix),
    .cmd_addr_o  (front_cmd.addr),
    .cmd_wx_o    (front_cmd.wx),
    .cmd_wy_o    (front_cmd.wy)
  );

  // -------------------------------------------------------------------------
  // Command queue: lets the front end run ahead while a query reads the store.
  // -------------------------------------------------------------------------
  brr_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .wdata_i (front_cmd),
    .full_o  (cmdq_full),
    .pop_i   (back_pop),
    .rdata_o (back_cmd),
    .empty_o (cmdq_empty),
    .count_o (cmdq_count)
  );

  // -------------------------------------------------------------------------
  // Back end: frame store access and blending.
  // -------------------------------------------------------------------------
  brr_back #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmdq_empty && cmdq_count != '0),
    .cmd_pop_o   (back_pop),
    .cmd_op_i    (back_cmd.op),
    .cmd_pix_i   (back_cmd.pix),
    .cmd_addr_i  (back_cmd.addr),
    .cmd_wx_i    (back_cmd.wx),
    .cmd_wy_i    (back_cmd.wy),
    .res_valid_o (res_valid),
    .res_pix_o   (res_pix),
    .out_count_i (outq_count)
  );

  // -------------------------------------------------------------------------
  // Result queue: back end reserves a slot before starting each query, so a
  // push here never meets a full queue.
  // -------------------------------------------------------------------------
  brr_fifo #(
    .WIDTH (PIX_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .wdata_i (res_pix),
    .full_o  (outq_full),
    .pop_i   (pop),
    .rdata_o (out_pix),
    .empty_o (empty),
    .count_o (outq_count)
  );

  assign out_red_o   = out_pix.red;
  assign out_green_o = out_pix.green;
  assign out_blue_o  = out_pix.blue;

  `BRR_ASSERT_IMPLIES(a_out_push_room, clk_i, rst_ni, res_valid, !outq_full, "result dropped")

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// Bilinear RGB resize: self-checking testbench
// Loads RGB888 frames and fires destination-pixel queries through the input
// queue, predicting each interpolated pixel from an exact Q32 blend. A directed
// table covers extremes and corner behaviour, then random phases follow.
// ----------------------------------------------------------------------------
module tb_top;
  import brr_pkg::*;

  localparam int unsigned CLK_PERIOD    = 8;
  localparam int unsigned RESET_CYCLES  = 8;
  localparam int unsigned MAX_W         = 256;
  localparam int unsigned MAX_H         = 256;
  localparam int unsigned STORE_DEPTH   = MAX_W * MAX_H;
  // loads leave no result behind, so settle for longer than a query takes
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned LIMIT_CYCLES  = 600000;
  localparam int unsigned RAND_ITEMS    = 800;
  localparam int unsigned MAX_REPORTS   = 20;
  localparam int unsigned DIR_ROWS      = 38;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT-facing signals (inputs known from time zero)
  // ---------------------------------------------------------------------------
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 push        = 1'b0;
  logic                 full;
  logic                 operation_i = OP_LOAD;
  logic [CH_W-1:0]      red_i       = '0;
  logic [CH_W-1:0]      green_i     = '0;
  logic [CH_W-1:0]      blue_i      = '0;
  logic [COORD_W-1:0]   out_x_i     = '0;
  logic [COORD_W-1:0]   out_y_i     = '0;
  logic                 empty;
  logic                 pop         = 1'b0;
  logic [CH_W-1:0]      out_red_o;
  logic [CH_W-1:0]      out_green_o;
  logic [CH_W-1:0]      out_blue_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [REG_IDX_W-1:0] cfg_index_i = '0;
  logic [STEP_W-1:0]    cfg_data_i  = '0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  bilinear_rgb_resize dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .operation_i (operation_i),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .out_x_i     (out_x_i),
    .out_y_i     (out_y_i),
    .empty       (empty),
    .pop         (pop),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the block: registers, frame store, load pointer
  // ---------------------------------------------------------------------------
  brr_cfg_t     model_cfg;
  brr_pix_t     frame_mem   [STORE_DEPTH];
  bit           loaded_mask [STORE_DEPTH];  // entries written since reset
  int unsigned  loaded_prefix = 0;          // first entry never written
  int unsigned  load_ptr      = 0;
  brr_pix_t     pending_pixels [$];         // interpolated pixels still owed
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count    = 0;
  int           burst_left     = 0;

  // Register value 0 behaves as 1, anything above the store limit as the limit.
  function automatic int unsigned eff_dim(input bit [SIZE_W-1:0] v, input int unsigned cap);
    if (v == 0) return 1;
    if (v > cap) return cap;
    return v;
  endfunction

  // Half-pixel centre mapping on one axis: (2d+1)*step - 1.0 in Q17, floored
  // to Q16, clamped at zero; neighbours past the last index collapse onto it.
  function automatic void axis_neighbours(input bit [COORD_W-1:0] d,
                                          input bit [STEP_W-1:0] step,
                                          input int unsigned size,
                                          output int unsigned lo,
                                          output int unsigned hi,
                                          output bit [FRAC_W:0] wt);
    bit [63:0] q17;
    bit [63:0] q16;
    q17 = (64'(d) * 2 + 1) * 64'(step);
    q16 = (q17 > 64'd65536) ? ((q17 - 64'd65536) >> 1) : 64'd0;
    if ((q16 >> FRAC_W) >= 64'(size - 1)) begin
      lo = size - 1;
      hi = size - 1;
      wt = '0;
    end else begin
      lo = 32'(q16 >> FRAC_W);
      hi = lo + 1;
      wt = (FRAC_W + 1)'(q16[FRAC_W-1:0]);
    end
  endfunction

  // Bilinear blend of the four neighbours, exact Q32, rounded half up, saturated.
  function automatic brr_pix_t interp_pixel(input bit [COORD_W-1:0] ox,
                                            input bit [COORD_W-1:0] oy);
    int unsigned w, h, x0, x1, y0, y1;
    bit [FRAC_W:0] wx, wy;
    logic [PIX_W-1:0] p00, p10, p01, p11, acc;
    bit [63:0] a, b, c, d, top, bot, blend, rounded;
    w = eff_dim(model_cfg.src_width, MAX_W);
    h = eff_dim(model_cfg.src_height, MAX_H);
    axis_neighbours(ox, model_cfg.x_step, w, x0, x1, wx);
    axis_neighbours(oy, model_cfg.y_step, h, y0, y1, wy);
    p00 = frame_mem[y0 * w + x0];
    p10 = frame_mem[y0 * w + x1];
    p01 = frame_mem[y1 * w + x0];
    p11 = frame_mem[y1 * w + x1];
    for (int ch = 0; ch < 3; ch++) begin
      a = 64'(p00[PIX_W-1-CH_W*ch -: CH_W]);
      b = 64'(p10[PIX_W-1-CH_W*ch -: CH_W]);
      c = 64'(p01[PIX_W-1-CH_W*ch -: CH_W]);
      d = 64'(p11[PIX_W-1-CH_W*ch -: CH_W]);
      top     = a * (64'd65536 - 64'(wx)) + b * 64'(wx);
      bot     = c * (64'd65536 - 64'(wx)) + d * 64'(wx);
      blend   = top * (64'd65536 - 64'(wy)) + bot * 64'(wy);
      rounded = (blend + 64'h8000_0000) >> 32;
      if (rounded > 255) rounded = 255;
      acc[PIX_W-1-CH_W*ch -: CH_W] = rounded[CH_W-1:0];
    end
    return brr_pix_t'(acc);
  endfunction

  // Raster-order write; pointer wraps at width*height, even if already past it.
  function automatic void store_pixel(input brr_pix_t pix);
    int unsigned total;
    total = eff_dim(model_cfg.src_width, MAX_W) * eff_dim(model_cfg.src_height, MAX_H);
    frame_mem[load_ptr]   = pix;
    loaded_mask[load_ptr] = 1'b1;
    while (loaded_prefix < STORE_DEPTH && loaded_mask[loaded_prefix]) loaded_prefix++;
    load_ptr = (load_ptr + 1 >= total) ? 0 : load_ptr + 1;
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input logic [PIX_W-1:0] want,
                               input logic [PIX_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // Input side: bursts of transactions separated by random gaps
  // ---------------------------------------------------------------------------
  task automatic send_item(input brr_op_e op, input brr_pix_t pix,
                           input bit [COORD_W-1:0] x, input bit [COORD_W-1:0] y);
    if (burst_left <= 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      // now and then a long run with push held high throughout
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
    end
    push        <= 1'b1;
    operation_i <= op;
    red_i       <= pix.red;
    green_i     <= pix.green;
    blue_i      <= pix.blue;
    out_x_i     <= x;
    out_y_i     <= y;
    do @(posedge clk_i); while (full);
    burst_left--;
  endtask

  // One input transaction plus its effect on the shadow; a typed-in value
  // overrides the predicted pixel where the answer is obvious.
  task automatic run_item(input brr_op_e op, input brr_pix_t pix,
                          input bit [COORD_W-1:0] x, input bit [COORD_W-1:0] y,
                          input bit typed, input brr_pix_t want);
    send_item(op, pix, x, y);
    if (op == OP_LOAD) store_pixel(pix);
    else pending_pixels.push_back(typed ? want : interp_pixel(x, y));
  endtask

  // Register write, only once everything in flight has drained.
  task automatic write_reg(input brr_reg_e idx, input logic [STEP_W-1:0] data);
    push <= 1'b0;
    burst_left = 0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_SRC_WIDTH:  model_cfg.src_width  = data[SIZE_W-1:0];
      REG_SRC_HEIGHT: model_cfg.src_height = data[SIZE_W-1:0];
      REG_X_STEP:     model_cfg.x_step     = data;
      REG_Y_STEP:     model_cfg.y_step     = data;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Random field choices
  // ---------------------------------------------------------------------------
  function automatic bit [STEP_W-1:0] random_step();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      2:       return STEP_W'(256);
      3:       return STEP_W'(16777216);
      4:       return STEP_W'(65536);
      5, 6:    return STEP_W'($urandom_range(256, 65536));      // upscale
      default: return STEP_W'($urandom_range(256, 4 * 65536));
    endcase
  endfunction

  // Mostly coordinates that land inside the source, some at the edges or anywhere.
  function automatic bit [COORD_W-1:0] random_coord(input int unsigned size,
                                                    input bit [STEP_W-1:0] step);
    int unsigned reach;
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return COORD_W'($urandom);
      default: begin
        reach = (step == 0) ? 4 : (size * 65536) / step + 2;
        if (reach > 65535) reach = 65535;
        return COORD_W'($urandom_range(0, reach));
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    brr_reg_e           reg_idx;
    logic [STEP_W-1:0]  data;
    brr_op_e            op;
    brr_pix_t           pix;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               typed;
    brr_pix_t           want;
  } row_t;

  function automatic row_t cfg_row(input brr_reg_e idx, input logic [STEP_W-1:0] data);
    row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic row_t load_row(input logic [PIX_W-1:0] pix);
    row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.op = OP_LOAD;
    r.pix = pix;
    return r;
  endfunction

  function automatic row_t query_row(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.op = OP_QUERY;
    r.x = x;
    r.y = y;
    return r;
  endfunction

  function automatic row_t known_row(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                     input logic [PIX_W-1:0] want);
    row_t r;
    r = query_row(x, y);
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  row_t dir_table [DIR_ROWS];

  // ---------------------------------------------------------------------------
  // Result side: stall pattern changes every so often; check every transaction
  // ---------------------------------------------------------------------------
  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_e;

  rx_mode_e    rx_mode = RX_FREE;
  int unsigned rx_left = 0;
  logic [31:0] rx_bits = '0;
  brr_pix_t    expected_head;

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_pixels.size() == 0) begin
        flag_mismatch("unexpected result", '0, {out_red_o, out_green_o, out_blue_o});
      end else begin
        expected_head = pending_pixels.pop_front();
        if (out_red_o != expected_head.red)
          flag_mismatch("out_red", PIX_W'(expected_head.red), PIX_W'(out_red_o));
        if (out_green_o != expected_head.green)
          flag_mismatch("out_green", PIX_W'(expected_head.green), PIX_W'(out_green_o));
        if (out_blue_o != expected_head.blue)
          flag_mismatch("out_blue", PIX_W'(expected_head.blue), PIX_W'(out_blue_o));
      end
    end
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 128);
      rx_bits = $urandom;
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_FREE:   pop <= 1'b1;
      RX_COIN:   pop <= 1'($urandom_range(0, 1));
      RX_SPARSE: pop <= ($urandom_range(0, 7) == 0);
      default: begin
        pop <= rx_bits[0];
        rx_bits = {rx_bits[0], rx_bits[31:1]};
      end
    endcase
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned phase;
    int unsigned total;
    int unsigned rand_items;
    int unsigned mix_len;
    bit [SIZE_W-1:0] w_reg;
    bit [SIZE_W-1:0] h_reg;

    model_cfg.src_width  = SIZE_W'(256);
    model_cfg.src_height = SIZE_W'(256);
    model_cfg.x_step     = STEP_W'(65536);
    model_cfg.y_step     = STEP_W'(65536);

    // Reset state is 256x256 at unit steps; everything below starts from a
    // 2x2 frame so that each query only touches loaded pixels.
    dir_table = '{
      cfg_row(REG_SRC_WIDTH, 25'd2),
      cfg_row(REG_SRC_HEIGHT, 25'd2),
      load_row(24'hFFFFFF),
      load_row(24'h000000),
      load_row(24'h010203),
      load_row(24'hFEFDFC),
      known_row(16'd0, 16'd0, 24'hFFFFFF),           // exact source centre
      known_row(16'd1, 16'd1, 24'hFEFDFC),
      known_row(16'hFFFF, 16'hFFFF, 24'hFEFDFC),     // beyond the image: clamp
      known_row(16'd0, 16'd1, 24'h010203),
      known_row(16'd1, 16'd0, 24'h000000),
      cfg_row(REG_X_STEP, 25'd32768),                // 2x upscale, fractional weights
      cfg_row(REG_Y_STEP, 25'd32768),
      query_row(16'd1, 16'd0),
      query_row(16'd1, 16'd1),
      query_row(16'd2, 16'd3),
      cfg_row(REG_X_STEP, 25'd0),                    // zero step pins column 0
      cfg_row(REG_Y_STEP, 25'h1FFFFFF),
      known_row(16'hFFFF, 16'd0, 24'h010203),
      cfg_row(REG_X_STEP, 25'd256),
      cfg_row(REG_Y_STEP, 25'd16777216),
      known_row(16'd0, 16'd0, 24'h010203),
      query_row(16'hFFFF, 16'd0),
      load_row(24'h112233),                          // pointer moves to 3
      load_row(24'h445566),
      load_row(24'h778899),
      cfg_row(REG_SRC_WIDTH, 25'd0),                 // zero size acts as one
      cfg_row(REG_SRC_HEIGHT, 25'd0),
      load_row(24'hAABBCC),                          // pointer past new size: wraps
      load_row(24'h5AA53C),
      known_row(16'd300, 16'd7, 24'h5AA53C),         // single pixel image
      cfg_row(REG_SRC_WIDTH, 25'd511),               // above maximum acts as 256
      load_row(24'h0FF081),
      known_row(16'd0, 16'd0, 24'h0FF081),
      cfg_row(REG_SRC_WIDTH, 25'd1),                 // single column, tall image
      cfg_row(REG_SRC_HEIGHT, 25'd511),
      cfg_row(REG_Y_STEP, 25'd256),
      known_row(16'd5, 16'd0, 24'h0FF081)
    };

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_table[i].kind == ROW_CFG)
        write_reg(dir_table[i].reg_idx, dir_table[i].data);
      else
        run_item(dir_table[i].op, dir_table[i].pix, dir_table[i].x, dir_table[i].y,
                 dir_table[i].typed, dir_table[i].want);
    end

    // Random phases: new geometry and steps, one full frame in raster order,
    // then mostly queries with a few loads over the top. Phase 1 uses the
    // largest width in one row, phase 4 (if reached) the largest height in one column; the rest stay small.
    rand_items = 0;
    phase      = 0;
    while (rand_items < RAND_ITEMS) begin
      case (phase)
        1: begin
          w_reg = SIZE_W'($urandom_range(256, 511));
          h_reg = SIZE_W'(1);
        end
        4: begin
          w_reg = SIZE_W'(1);
          h_reg = SIZE_W'($urandom_range(256, 511));
        end
        default: begin
          w_reg = SIZE_W'($urandom_range(0, 12));
          h_reg = SIZE_W'($urandom_range(0, 12));
        end
      endcase
      write_reg(REG_SRC_WIDTH, STEP_W'(w_reg));
      write_reg(REG_SRC_HEIGHT, STEP_W'(h_reg));
      write_reg(REG_X_STEP, random_step());
      write_reg(REG_Y_STEP, random_step());
      total = eff_dim(model_cfg.src_width, MAX_W) * eff_dim(model_cfg.src_height, MAX_H);

      repeat (total) begin
        run_item(OP_LOAD, PIX_W'($urandom), COORD_W'($urandom), COORD_W'($urandom), 1'b0, '0);
        rand_items++;
      end
      // pointer may have started past the frame; top up until all of it is loaded
      while (loaded_prefix < total) begin
        run_item(OP_LOAD, PIX_W'($urandom), COORD_W'($urandom), COORD_W'($urandom), 1'b0, '0);
        rand_items++;
      end

      mix_len = $urandom_range(40, 80);
      repeat (mix_len) begin
        if ($urandom_range(0, 4) == 0)
          run_item(OP_LOAD, PIX_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                   1'b0, '0);
        else
          run_item(OP_QUERY, PIX_W'($urandom),
                   random_coord(eff_dim(model_cfg.src_width, MAX_W), model_cfg.x_step),
                   random_coord(eff_dim(model_cfg.src_height, MAX_H), model_cfg.y_step),
                   1'b0, '0);
        rand_items++;
      end
      phase++;
    end

    // Drain, then give the back end time to show any stray result.
    push <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/brr_pkg.sv
hw/rtl/brr_ram.sv
hw/rtl/brr_fifo.sv
hw/rtl/brr_front.sv
hw/rtl/brr_back.sv
hw/rtl/bilinear_rgb_resize.sv
test/tb_top.sv
